>>> rtl/core/perceptron_trainer_macros.svh
`ifndef PERCEPTRON_TRAINER_MACROS_SVH
`define PERCEPTRON_TRAINER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PTR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ptr_pkg.sv
package ptr_pkg;

	localparam int WEIGHT_W   = 24;
	localparam int SUM_W      = 32;
	localparam int COUNT_W    = 21;
	localparam int THRESH_W   = 16;
	localparam int ITER_W     = 20;
	localparam int DIVL_W     = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam int THRESH_SHIFT = 9;

	localparam logic [ITER_W-1:0] ITER_LIMIT_RST = 20'd100000;
	localparam logic [DIVL_W-1:0] DIV_LIMIT_RST  = 31'd25600;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_CONV  = 2'd1,
		ST_LIMIT = 2'd2,
		ST_DIV   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD  = 2'd0,
		REG_ITER_LIMIT = 2'd1,
		REG_DIV_LIMIT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic train;
		logic target;
		logic epoch_end;
		logic pred;
	} learn_ctl_t;

endpackage

>>> rtl/core/ptr_req_if.sv
interface ptr_req_if #(
	parameter int LANES        = 2,
	parameter int FEATURE_BITS = 16
);
	logic                           valid;
	logic                           ready;
	logic                           func;
	logic signed [FEATURE_BITS-1:0] feature [LANES];
	logic                           target;
	logic                           epoch_end;

	modport source (output valid, func, feature, target, epoch_end, input ready);
	modport sink (input valid, func, feature, target, epoch_end, output ready);
endinterface

>>> rtl/core/ptr_rsp_if.sv
interface ptr_rsp_if;
	logic             valid;
	logic             ready;
	logic             prediction;
	logic             epoch_done;
	ptr_pkg::status_t status;

	modport source (output valid, prediction, epoch_done, status, input ready);
	modport sink (input valid, prediction, epoch_done, status, output ready);
endinterface

>>> rtl/core/perceptron_trainer.sv
// an accepted request waits in the input register until the result register is free or being read
// throughput: one request per cycle while results are taken; the weights are read and updated in the same cycle
// an input register and a result register decouple the two channels
// reset clears weights, counters, change sums and status (running)
// reset loads threshold 0, iteration limit 100000, divergence limit 25600
`include "perceptron_trainer_macros.svh"

module perceptron_trainer #(
	parameter int LANES        = 2,
	parameter int FEATURE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ptr_req_if.sink                           req,
	ptr_rsp_if.source                         rsp,
	input  logic                              cfg_we,
	input  logic [ptr_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [ptr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int XS_W = FEATURE_BITS + $clog2(LANES) + 1;

	logic signed [ptr_pkg::THRESH_W-1:0] threshold_q;
	logic [ptr_pkg::ITER_W-1:0]          iteration_limit_q;
	logic [ptr_pkg::DIVL_W-1:0]          divergence_limit_q;

	logic                           valid_s1;
	logic                           func_s1;
	logic signed [FEATURE_BITS-1:0] feature_s1 [LANES];
	logic                           target_s1;
	logic                           epoch_end_s1;

	logic                           rsp_valid_q;
	logic                           pred_q;
	logic                           done_q;
	ptr_pkg::status_t               status_q;

	logic                                advance;
	logic                                pred;
	logic signed [XS_W-1:0]              xsum;
	logic signed [ptr_pkg::WEIGHT_W-1:0] weight [LANES];
	ptr_pkg::status_t                    status_next;
	ptr_pkg::learn_ctl_t                 ctl;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q        <= '0;
			iteration_limit_q  <= ptr_pkg::ITER_LIMIT_RST;
			divergence_limit_q <= ptr_pkg::DIV_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (ptr_pkg::reg_idx_t'(cfg_idx))
				ptr_pkg::REG_THRESHOLD: begin
					threshold_q <= $signed(cfg_data[ptr_pkg::THRESH_W-1:0]);
				end
				ptr_pkg::REG_ITER_LIMIT: begin
					iteration_limit_q <= cfg_data[ptr_pkg::ITER_W-1:0];
				end
				ptr_pkg::REG_DIV_LIMIT: begin
					divergence_limit_q <= cfg_data[ptr_pkg::DIVL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1      <= req.func;
			feature_s1   <= req.feature;
			target_s1    <= req.target;
			epoch_end_s1 <= req.epoch_end;
		end
	end

	ptr_neuron #(
		.LANES        (LANES),
		.FEATURE_BITS (FEATURE_BITS),
		.XS_W         (XS_W)
	) u_neuron (
		.x         (feature_s1),
		.weight    (weight),
		.threshold (threshold_q),
		.pred      (pred),
		.xsum      (xsum)
	);

	assign ctl.train     = !func_s1;
	assign ctl.target    = target_s1;
	assign ctl.epoch_end = epoch_end_s1;
	assign ctl.pred      = pred;

	ptr_learn #(
		.LANES        (LANES),
		.FEATURE_BITS (FEATURE_BITS),
		.XS_W         (XS_W)
	) u_learn (
		.clk              (clk),
		.arst_n           (arst_n),
		.upd_en           (advance),
		.ctl              (ctl),
		.x                (feature_s1),
		.xsum             (xsum),
		.iteration_limit  (iteration_limit_q),
		.divergence_limit (divergence_limit_q),
		.weight           (weight),
		.status_next      (status_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pred_q   <= pred;
			done_q   <= ctl.train & epoch_end_s1;
			status_q <= status_next;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.prediction = pred_q;
	assign rsp.epoch_done = done_q;
	assign rsp.status     = status_q;

	`PTR_ASSERT_NOW(a_stall_holds_s1, !req.ready, valid_s1 && rsp_valid_q && !rsp.ready, "request stalled with a free stage")
	`PTR_ASSERT_NEXT(a_advance_fills_rsp, advance, rsp_valid_q, "advanced request produced no result")
endmodule

>>> rtl/core/ptr_neuron.sv
module ptr_neuron #(
	parameter int LANES        = 2,
	parameter int FEATURE_BITS = 16,
	parameter int XS_W         = FEATURE_BITS + $clog2(LANES) + 1
) (
	input  logic signed [FEATURE_BITS-1:0]      x [LANES],
	input  logic signed [ptr_pkg::WEIGHT_W-1:0] weight [LANES],
	input  logic signed [ptr_pkg::THRESH_W-1:0] threshold,
	output logic                                pred,
	output logic signed [XS_W-1:0]              xsum
);
	localparam int PROD_W = FEATURE_BITS + ptr_pkg::WEIGHT_W;
	localparam int ACC_W  = PROD_W + $clog2(LANES) + 1;
	localparam int THS_W  = ptr_pkg::THRESH_W + ptr_pkg::THRESH_SHIFT;

	logic signed [PROD_W-1:0] prod [LANES];
	logic signed [ACC_W-1:0]  acc;
	logic signed [THS_W-1:0]  thr_sc;

	// one multiplier per lane, then the adder tree
	always_comb begin
		acc  = '0;
		xsum = '0;
		for (int i = 0; i < LANES; i++) begin
			prod[i] = PROD_W'(x[i]) * PROD_W'(weight[i]);
			acc     = acc + ACC_W'(prod[i]);
			xsum    = xsum + XS_W'(x[i]);
		end
	end

	assign thr_sc = {threshold, {ptr_pkg::THRESH_SHIFT{1'b0}}};
	assign pred   = (acc >= ACC_W'(thr_sc));
endmodule

>>> rtl/core/ptr_learn.sv
`include "perceptron_trainer_macros.svh"

module ptr_learn #(
	parameter int LANES        = 2,
	parameter int FEATURE_BITS = 16,
	parameter int XS_W         = FEATURE_BITS + $clog2(LANES) + 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                upd_en,
	input  ptr_pkg::learn_ctl_t                 ctl,
	input  logic signed [FEATURE_BITS-1:0]      x [LANES],
	input  logic signed [XS_W-1:0]              xsum,
	input  logic [ptr_pkg::ITER_W-1:0]          iteration_limit,
	input  logic [ptr_pkg::DIVL_W-1:0]          divergence_limit,
	output logic signed [ptr_pkg::WEIGHT_W-1:0] weight [LANES],
	output ptr_pkg::status_t                    status_next
);
	localparam int WEIGHT_W = ptr_pkg::WEIGHT_W;
	localparam int SUM_W    = ptr_pkg::SUM_W;
	localparam int COUNT_W  = ptr_pkg::COUNT_W;
	localparam int UPD_W    = ((FEATURE_BITS > WEIGHT_W) ? FEATURE_BITS : WEIGHT_W) + 1;
	localparam int CH_W     = XS_W + 1;
	localparam int CS_W     = ((CH_W > SUM_W) ? CH_W : SUM_W) + 1;

	localparam logic signed [UPD_W-1:0] W_MAX = UPD_W'((2 ** (WEIGHT_W - 1)) - 1);
	localparam logic signed [UPD_W-1:0] W_MIN = UPD_W'(-(2 ** (WEIGHT_W - 1)));
	localparam logic signed [CS_W-1:0]  S_MAX = CS_W'(64'sd2147483647);
	localparam logic signed [CS_W-1:0]  S_MIN = CS_W'(-64'sd2147483648);
	localparam logic [COUNT_W-1:0]      COUNT_MAX = '1;

	logic signed [WEIGHT_W-1:0] weight_q [LANES];
	logic signed [WEIGHT_W-1:0] weight_d [LANES];
	logic signed [UPD_W-1:0]    wsum [LANES];
	logic                       had_err_q;
	logic [COUNT_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]    ecs_q;
	logic signed [SUM_W-1:0]    first_q;
	logic                       first_seen_q;
	ptr_pkg::status_t           status_q;

	logic                       do_upd;
	logic                       err_pos;
	logic                       err_neg;
	logic signed [CH_W-1:0]     change;
	logic signed [CS_W-1:0]     csum;
	logic signed [CS_W-1:0]     ch_ext;
	logic signed [SUM_W-1:0]    ecs_new;
	logic signed [SUM_W-1:0]    first_new;
	logic                       had_err_new;
	logic [COUNT_W-1:0]         cnt_new;
	logic signed [SUM_W:0]      gap;
	logic [SUM_W:0]             gap_abs;
	logic                       diverged;

	assign do_upd  = upd_en && ctl.train && (status_q == ptr_pkg::ST_RUN);
	assign err_pos = ctl.target & ~ctl.pred;
	assign err_neg = ~ctl.target & ctl.pred;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (err_pos) begin
				wsum[i] = UPD_W'(weight_q[i]) + UPD_W'(x[i]);
			end else if (err_neg) begin
				wsum[i] = UPD_W'(weight_q[i]) - UPD_W'(x[i]);
			end else begin
				wsum[i] = UPD_W'(weight_q[i]);
			end
			if (wsum[i] > W_MAX) begin
				weight_d[i] = W_MAX[WEIGHT_W-1:0];
			end else if (wsum[i] < W_MIN) begin
				weight_d[i] = W_MIN[WEIGHT_W-1:0];
			end else begin
				weight_d[i] = wsum[i][WEIGHT_W-1:0];
			end
		end
	end

	always_comb begin
		if (err_pos) begin
			change = CH_W'(xsum);
		end else if (err_neg) begin
			change = -CH_W'(xsum);
		end else begin
			change = '0;
		end
		ch_ext = CS_W'(change);
		csum   = CS_W'(ecs_q) + ch_ext;
		if (csum > S_MAX) begin
			ecs_new = S_MAX[SUM_W-1:0];
		end else if (csum < S_MIN) begin
			ecs_new = S_MIN[SUM_W-1:0];
		end else begin
			ecs_new = csum[SUM_W-1:0];
		end
		if (first_seen_q) begin
			first_new = first_q;
		end else if (ch_ext > S_MAX) begin
			first_new = S_MAX[SUM_W-1:0];
		end else if (ch_ext < S_MIN) begin
			first_new = S_MIN[SUM_W-1:0];
		end else begin
			first_new = ch_ext[SUM_W-1:0];
		end
	end

	assign had_err_new = had_err_q | err_pos | err_neg;
	assign cnt_new     = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign gap         = (SUM_W + 1)'(ecs_new) - (SUM_W + 1)'(first_new);
	assign gap_abs     = gap[SUM_W] ? (SUM_W + 1)'(-gap) : (SUM_W + 1)'(gap);
	assign diverged    = gap_abs > (SUM_W + 1)'({divergence_limit, 1'b0});

	// epoch close: divergence first, then convergence, then iteration limit
	always_comb begin
		status_next = status_q;
		if (do_upd && ctl.epoch_end) begin
			if (diverged) begin
				status_next = ptr_pkg::ST_DIV;
			end else if (!had_err_new) begin
				status_next = ptr_pkg::ST_CONV;
			end else if (cnt_new > COUNT_W'(iteration_limit)) begin
				status_next = ptr_pkg::ST_LIMIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				weight_q[i] <= '0;
			end
			had_err_q    <= 1'b0;
			cnt_q        <= '0;
			ecs_q        <= '0;
			first_q      <= '0;
			first_seen_q <= 1'b0;
			status_q     <= ptr_pkg::ST_RUN;
		end else if (do_upd) begin
			for (int i = 0; i < LANES; i++) begin
				weight_q[i] <= weight_d[i];
			end
			had_err_q    <= ctl.epoch_end ? 1'b0 : had_err_new;
			cnt_q        <= cnt_new;
			ecs_q        <= ctl.epoch_end ? '0 : ecs_new;
			first_q      <= first_new;
			first_seen_q <= 1'b1;
			status_q     <= status_next;
		end
	end

	assign weight = weight_q;

	`PTR_ASSERT_NEXT(a_status_sticky, status_q != ptr_pkg::ST_RUN, $stable(status_q), "status left a final state")
	`PTR_ASSERT_NEXT(a_epoch_clears_err, do_upd && ctl.epoch_end, !had_err_q && ecs_q == '0, "epoch close did not clear epoch state")
	`PTR_ASSERT_NEXT(a_count_step, do_upd && cnt_q != COUNT_MAX, cnt_q == $past(cnt_q) + 1'b1, "sample count missed a training request")
endmodule

>>> sim/perceptron_trainer_checker.sv
`timescale 1ns / 100ps

package ptr_tb_pkg;
	localparam logic FUNC_TRAIN   = 1'b0;
	localparam logic FUNC_PREDICT = 1'b1;
endpackage

module perceptron_trainer_checker #(
	parameter int LANES        = 2,
	parameter int FEATURE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ptr_req_if                             req,
	ptr_rsp_if                             rsp,
	input  logic                           cfg_we,
	input  logic [ptr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ptr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fails,
	output int                             pending
);
	import ptr_pkg::*;
	import ptr_tb_pkg::*;

	typedef struct packed {
		logic    prediction;
		logic    epoch_done;
		status_t status;
	} outcome_t;

	localparam longint WEIGHT_HI = (longint'(1) <<< (WEIGHT_W - 1)) - 1;
	localparam longint WEIGHT_LO = -(longint'(1) <<< (WEIGHT_W - 1));
	localparam longint SUM_HI    = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint SUM_LO    = -(longint'(1) <<< (SUM_W - 1));

	logic signed [WEIGHT_W-1:0] wt [LANES];
	logic                       epoch_missed;
	logic [COUNT_W-1:0]         trained;
	logic signed [SUM_W-1:0]    drift;
	logic signed [SUM_W-1:0]    first_drift;
	logic                       first_done;
	status_t                    mode;

	logic signed [THRESH_W-1:0] thr;
	logic [ITER_W-1:0]          iter_cap;
	logic [DIVL_W-1:0]          drift_cap;

	outcome_t predicted_q [$];
	outcome_t want;
	int       errs = 0;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// one request through the learning rule, state updated in place
	function automatic outcome_t learn(input logic fn,
			input logic signed [FEATURE_BITS-1:0] x [LANES], input logic tgt,
			input logic eend);
		longint   acc;
		longint   xsum;
		longint   err;
		longint   gap;
		int       i;
		outcome_t r;
		acc = 0;
		xsum = 0;
		for (i = 0; i < LANES; i++) begin
			acc += longint'(x[i]) * longint'(wt[i]);
			xsum += longint'(x[i]);
		end
		r.prediction = (acc >= longint'(thr) * (longint'(1) <<< THRESH_SHIFT));
		r.epoch_done = 1'b0;
		if (fn == FUNC_TRAIN) begin
			r.epoch_done = eend;
			if (mode == ST_RUN) begin
				err = longint'(tgt) - longint'(r.prediction);
				for (i = 0; i < LANES; i++)
					wt[i] = clip(longint'(wt[i]) + err * longint'(x[i]), WEIGHT_LO, WEIGHT_HI);
				if (err != 0)
					epoch_missed = 1'b1;
				if (trained != '1)
					trained = trained + 1'b1;
				drift = clip(longint'(drift) + err * xsum, SUM_LO, SUM_HI);
				if (!first_done) begin
					first_drift = clip(err * xsum, SUM_LO, SUM_HI);
					first_done = 1'b1;
				end
				if (eend) begin
					gap = longint'(drift) - longint'(first_drift);
					if (gap < 0)
						gap = -gap;
					if (gap > 2 * longint'(drift_cap))
						mode = ST_DIV;
					else if (!epoch_missed)
						mode = ST_CONV;
					else if (longint'(trained) > longint'(iter_cap))
						mode = ST_LIMIT;
					epoch_missed = 1'b0;
					drift = '0;
				end
			end
		end
		r.status = mode;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++)
				wt[i] = '0;
			epoch_missed = 1'b0;
			trained = '0;
			drift = '0;
			first_drift = '0;
			first_done = 1'b0;
			mode = ST_RUN;
			thr = '0;
			iter_cap = ITER_LIMIT_RST;
			drift_cap = DIV_LIMIT_RST;
			predicted_q.delete();
			pending <= 0;
			fails <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_THRESHOLD:  thr = cfg_data[THRESH_W-1:0];
					REG_ITER_LIMIT: iter_cap = cfg_data[ITER_W-1:0];
					REG_DIV_LIMIT:  drift_cap = cfg_data[DIVL_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (predicted_q.size() == 0) begin
					$error("result with no request outstanding");
					errs++;
				end else begin
					want = predicted_q.pop_front();
					if (rsp.prediction !== want.prediction) begin
						$error("prediction: expected %0d, got %0d", want.prediction,
							rsp.prediction);
						errs++;
					end
					if (rsp.epoch_done !== want.epoch_done) begin
						$error("epoch_done: expected %0d, got %0d", want.epoch_done,
							rsp.epoch_done);
						errs++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errs++;
					end
				end
			end
			if (req.valid && req.ready)
				predicted_q.push_back(learn(req.func, req.feature, req.target, req.epoch_end));
			pending <= predicted_q.size();
			fails <= errs;
		end
	end
endmodule

>>> sim/perceptron_trainer_tb.sv
`timescale 1ns / 100ps

module perceptron_trainer_tb;
	import ptr_pkg::*;
	import ptr_tb_pkg::*;

	localparam int LANES        = 2;
	localparam int FEATURE_BITS = 16;
	localparam int PHASE_ITEMS  = 125;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic signed [FEATURE_BITS-1:0] X_MIN = {1'b1, {(FEATURE_BITS - 1){1'b0}}};
	localparam logic signed [FEATURE_BITS-1:0] X_MAX = {1'b0, {(FEATURE_BITS - 1){1'b1}}};
	localparam logic signed [THRESH_W-1:0]     THR_MIN = {1'b1, {(THRESH_W - 1){1'b0}}};
	localparam logic signed [THRESH_W-1:0]     THR_MAX = {1'b0, {(THRESH_W - 1){1'b1}}};
	localparam logic [ITER_W-1:0]              ITER_MAX = '1;
	localparam logic [DIVL_W-1:0]              DIV_MAX = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fails;
	int                    pending;

	logic                  no_idle = 1'b0;
	logic signed [THRESH_W-1:0] thr_now = '0;
	int                    sent = 0;

	ptr_req_if #(.LANES(LANES), .FEATURE_BITS(FEATURE_BITS)) req ();
	ptr_rsp_if rsp ();

	perceptron_trainer #(.LANES(LANES), .FEATURE_BITS(FEATURE_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	perceptron_trainer_checker #(.LANES(LANES), .FEATURE_BITS(FEATURE_BITS)) chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.fails    (fails),
		.pending  (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic signed [FEATURE_BITS-1:0] pick_feature();
		case ($urandom_range(9))
			0: return X_MIN;
			1: return X_MAX;
			2: return '0;
			3, 4, 5: return FEATURE_BITS'($urandom_range(1023)) - FEATURE_BITS'(512);
			default: return FEATURE_BITS'($urandom);
		endcase
	endfunction

	task automatic push_item(input logic fn, input logic signed [FEATURE_BITS-1:0] x0,
			input logic signed [FEATURE_BITS-1:0] x1, input logic tgt, input logic eend);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= fn;
		req.feature[0] <= x0;
		req.feature[1] <= x1;
		req.target <= tgt;
		req.epoch_end <= eend;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_regs(input logic signed [THRESH_W-1:0] t, input logic [ITER_W-1:0] lim,
			input logic [DIVL_W-1:0] cap);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[THRESH_W-1:0] = t;
		cfg_we <= 1'b1;
		cfg_idx <= REG_THRESHOLD;
		cfg_data <= d;
		@(posedge clk);
		d = CFG_DATA_W'($urandom);
		d[ITER_W-1:0] = lim;
		cfg_idx <= REG_ITER_LIMIT;
		cfg_data <= d;
		@(posedge clk);
		cfg_idx <= REG_DIV_LIMIT;
		cfg_data <= cap;
		@(posedge clk);
		cfg_idx <= REG_SPARE;
		cfg_data <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_now = t;
	endtask

	// zero features give a known prediction, so the opening miss keeps the epoch from converging
	task automatic train_epoch();
		int len;
		len = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(40, 13);
		push_item(FUNC_TRAIN, '0, '0, thr_now > 0, 1'b0);
		repeat (len) begin
			if ($urandom_range(3) == 0)
				push_item(FUNC_PREDICT, pick_feature(), pick_feature(), 1'($urandom),
					1'($urandom));
			else
				push_item(FUNC_TRAIN, pick_feature(), pick_feature(), 1'($urandom), 1'b0);
		end
		push_item(FUNC_TRAIN, pick_feature(), pick_feature(), 1'($urandom), 1'b1);
	endtask

	initial begin : result_sink
		int n;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = idle_len();
			if (n > 0) begin
				rsp.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : watchdog
		#(20_000_000);
		$display("perceptron_trainer_tb failed");
		$finish;
	end

	initial begin : stimulus
		int                         phase;
		int                         goal;
		status_t                    ending;
		logic signed [THRESH_W-1:0] t;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_THRESHOLD;
		cfg_data <= '0;
		req.valid <= 1'b0;
		req.func <= FUNC_TRAIN;
		req.feature[0] <= '0;
		req.feature[1] <= '0;
		req.target <= 1'b0;
		req.epoch_end <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		push_item(FUNC_TRAIN, 16'sd100, 16'sd200, 1'b0, 1'b0);
		push_item(FUNC_TRAIN, '0, '0, 1'b0, 1'b1);
		push_item(FUNC_PREDICT, X_MIN, X_MIN, 1'b1, 1'b1);
		push_item(FUNC_PREDICT, X_MAX, X_MAX, 1'b0, 1'b1);
		push_item(FUNC_PREDICT, X_MAX, X_MIN, 1'b1, 1'b0);
		push_item(FUNC_PREDICT, X_MIN, X_MAX, 1'b0, 1'b0);
		push_item(FUNC_TRAIN, X_MAX, X_MAX, 1'b1, 1'b0);
		push_item(FUNC_TRAIN, X_MIN, X_MIN, 1'b1, 1'b0);
		push_item(FUNC_TRAIN, X_MIN, X_MAX, 1'b0, 1'b0);
		push_item(FUNC_TRAIN, X_MAX, X_MIN, 1'b0, 1'b0);
		push_item(FUNC_TRAIN, '0, '0, 1'b1, 1'b0);
		push_item(FUNC_TRAIN, -16'sd1, -16'sd1, 1'b1, 1'b0);
		push_item(FUNC_PREDICT, 16'sd1, -16'sd1, 1'b0, 1'b1);
		push_item(FUNC_PREDICT, X_MAX, X_MAX, 1'b1, 1'b0);
		drain();

		for (phase = 0; phase < 8; phase++) begin
			no_idle = (phase % 3 == 2);
			case (phase)
				0: t = THR_MIN;
				1: t = THR_MAX;
				2: t = '0;
				default: t = THRESH_W'($urandom);
			endcase
			load_regs(t, (phase == 1) ? ITER_MAX : ITER_W'($urandom_range(ITER_MAX, 4096)),
				(phase == 0) ? DIV_MAX : DIVL_W'($urandom_range(DIV_MAX, 1 << 26)));
			goal = sent + PHASE_ITEMS;
			while (sent < goal)
				train_epoch();
			drain();
		end
		no_idle = 1'b0;

		// one sticky outcome per run, picked at random
		case ($urandom_range(2))
			0: ending = ST_CONV;
			1: ending = ST_LIMIT;
			default: ending = ST_DIV;
		endcase
		case (ending)
			ST_CONV: begin
				load_regs(thr_now, ITER_MAX, DIV_MAX);
				push_item(FUNC_TRAIN, '0, '0, thr_now <= 0, 1'b1);
			end
			ST_LIMIT: begin
				load_regs(thr_now, '0, DIV_MAX);
				push_item(FUNC_TRAIN, '0, '0, thr_now > 0, 1'b1);
			end
			default: begin
				load_regs(thr_now, ITER_MAX, '0);
				push_item(FUNC_TRAIN, '0, '0, 1'($urandom), 1'b1);
			end
		endcase
		drain();

		// frozen weights from here on
		load_regs(THRESH_W'($urandom), ITER_MAX, DIV_MAX);
		repeat (150)
			push_item($urandom_range(1) ? FUNC_PREDICT : FUNC_TRAIN, pick_feature(),
				pick_feature(), 1'($urandom), 1'($urandom));
		drain();
		repeat (8) @(posedge clk);

		if (fails == 0) begin
			$display("perceptron_trainer_tb passed");
		end else begin
			$display("perceptron_trainer_tb failed");
		end
		$finish;
	end
endmodule
